// File: hw/rtl/rnu_pkg.sv
// ----------------------------------------------------------------------------
// rnu_pkg: shared definitions for the rational normaliser
// Default width and the status bundle reported by the iterative units.
// ----------------------------------------------------------------------------
`default_nettype none

package rnu_pkg;

    // Default width of the signed numerator and denominator.
    localparam int DATA_WIDTH_DEF = 32;

    // Status of an iterative unit: working, and a one-cycle finish pulse.
    typedef struct packed {
        logic busy;
        logic done;
    } t_unit_sts;

endpackage

`default_nettype wire

// File: hw/rtl/rnu_gcd.sv
// ----------------------------------------------------------------------------
// rnu_gcd: iterative binary greatest common divisor
// One shift or one subtract-and-shift per cycle on two nonzero magnitudes.
// ----------------------------------------------------------------------------
`default_nettype none

module rnu_gcd
    import rnu_pkg::*;
#(
    parameter int MAG_W = DATA_WIDTH_DEF - 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [MAG_W-1:0] i_a,
    input  wire logic [MAG_W-1:0] i_b,
    output t_unit_sts             o_sts,
    output logic      [MAG_W-1:0] o_gcd
);

    localparam int K_W = $clog2(MAG_W + 1);

    logic [MAG_W-1:0] r_a, n_a;
    logic [MAG_W-1:0] r_b, n_b;
    logic [K_W-1:0]   r_k, n_k;
    logic             r_busy;
    logic             r_done;
    logic [MAG_W-1:0] r_gcd;
    logic [MAG_W-1:0] w_diff;
    logic             w_a_gt_b;

    // One step of the binary algorithm; the shared subtractor takes the
    // larger operand minus the smaller one.
    always_comb begin
        w_a_gt_b = (r_a > r_b);
        w_diff   = w_a_gt_b ? (r_a - r_b) : (r_b - r_a);
        n_a      = r_a;
        n_b      = r_b;
        n_k      = r_k;
        if (!r_a[0] && !r_b[0]) begin
            n_a = r_a >> 1;
            n_b = r_b >> 1;
            n_k = r_k + K_W'(1);
        end else if (!r_a[0]) begin
            n_a = r_a >> 1;
        end else if (!r_b[0]) begin
            n_b = r_b >> 1;
        end else if (w_a_gt_b) begin
            n_a = w_diff >> 1;
        end else begin
            n_b = w_diff >> 1;
        end
    end

    // Operand registers and control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_a    <= i_a;
                r_b    <= i_b;
                r_k    <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (r_a == r_b) begin
                    // Equal operands: restore the common factors of two.
                    r_gcd  <= r_a << r_k;
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_a <= n_a;
                    r_b <= n_b;
                    r_k <= n_k;
                end
            end
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_gcd      = r_gcd;

endmodule

`default_nettype wire

// File: hw/rtl/rnu_div.sv
// ----------------------------------------------------------------------------
// rnu_div: restoring unsigned divider
// One quotient bit per cycle, MAG_W quotient bits per division.
// ----------------------------------------------------------------------------
`default_nettype none

module rnu_div
    import rnu_pkg::*;
#(
    parameter int MAG_W = DATA_WIDTH_DEF - 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [MAG_W-1:0] i_dividend,
    input  wire logic [MAG_W-1:0] i_divisor,
    output t_unit_sts             o_sts,
    output logic      [MAG_W-1:0] o_quotient
);

    localparam int CNT_W = $clog2(MAG_W + 1);

    logic [MAG_W:0]   r_rem;
    logic [MAG_W-1:0] r_quo;
    logic [MAG_W-1:0] r_dsr;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [MAG_W:0]   w_shift;
    logic             w_fits;

    // Bring down the next dividend bit and trial-subtract the divisor.
    always_comb begin
        w_shift = {r_rem[MAG_W-1:0], r_quo[MAG_W-1]};
        w_fits  = (w_shift >= {1'b0, r_dsr});
    end

    // Remainder, quotient and step counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_rem  <= '0;
                r_quo  <= i_dividend;
                r_dsr  <= i_divisor;
                r_cnt  <= CNT_W'(MAG_W);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem <= w_fits ? (w_shift - {1'b0, r_dsr}) : w_shift;
                r_quo <= {r_quo[MAG_W-2:0], w_fits};
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_quotient = r_quo;

endmodule

`default_nettype wire

// File: hw/rtl/rational_normalizer_unit.sv
// ----------------------------------------------------------------------------
// rational_normalizer_unit: reduces a signed fraction to lowest terms
// Divides both magnitudes by their greatest common divisor, puts the sign
// on the numerator and keeps the denominator positive.
//
//   Channel | Signals                                        | Direction
//   --------+------------------------------------------------+----------
//   in      | i_in_valid, o_in_ready, i_numerator_in,        | into block
//           | i_denominator_in                               |
//   out     | o_out_valid, i_out_ready, o_numerator_out,     | from block
//           | o_denominator_out, o_zero_divisor              |
//
// An item with a zero numerator or a zero denominator skips straight to the
// result. Otherwise the binary gcd steps run first, then two divisions on
// the shared restoring divider, the numerator first and then the denominator.
// One item is in work at a time; o_in_ready is high only while idle.
// The result is held until taken; synchronous active-low reset clears the valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module rational_normalizer_unit
    import rnu_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_in_valid,
    output logic                              o_in_ready,
    input  wire logic signed [DATA_WIDTH-1:0] i_numerator_in,
    input  wire logic signed [DATA_WIDTH-1:0] i_denominator_in,
    output logic                              o_out_valid,
    input  wire logic                         i_out_ready,
    output logic signed      [DATA_WIDTH-1:0] o_numerator_out,
    output logic             [DATA_WIDTH-2:0] o_denominator_out,
    output logic                              o_zero_divisor
);

    localparam int MAG_W = DATA_WIDTH - 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_GCD,
        S_DIVN,
        S_DIVD,
        S_OUT
    } t_state;

    t_state           r_state;
    logic [MAG_W-1:0] r_na;
    logic [MAG_W-1:0] r_da;
    logic             r_neg;
    logic [MAG_W-1:0] r_g;
    logic [MAG_W-1:0] r_qn;
    logic             r_gcd_start;
    logic             r_div_start;

    logic [DATA_WIDTH-1:0] w_num_abs;
    logic [DATA_WIDTH-1:0] w_den_abs;
    logic [MAG_W-1:0]      w_na;
    logic [MAG_W-1:0]      w_da;
    logic [DATA_WIDTH-1:0] w_qn_ext;
    logic [MAG_W-1:0]      w_dividend;
    t_unit_sts             w_gcd_sts;
    t_unit_sts             w_div_sts;
    logic [MAG_W-1:0]      w_gcd;
    logic [MAG_W-1:0]      w_quotient;

    // Magnitudes of the inputs; the most negative value saturates.
    always_comb begin
        w_num_abs = i_numerator_in[DATA_WIDTH-1] ? (-i_numerator_in) : i_numerator_in;
        w_den_abs = i_denominator_in[DATA_WIDTH-1] ? (-i_denominator_in)
                                                   : i_denominator_in;
        w_na      = w_num_abs[DATA_WIDTH-1] ? {MAG_W{1'b1}} : w_num_abs[MAG_W-1:0];
        w_da      = w_den_abs[DATA_WIDTH-1] ? {MAG_W{1'b1}} : w_den_abs[MAG_W-1:0];
        w_qn_ext  = {1'b0, r_qn};
    end

    // The divider serves the numerator first, then the denominator.
    assign w_dividend = (r_state == S_DIVN) ? r_na : r_da;

    rnu_gcd #(
        .MAG_W (MAG_W)
    ) u_gcd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_gcd_start),
        .i_a     (r_na),
        .i_b     (r_da),
        .o_sts   (w_gcd_sts),
        .o_gcd   (w_gcd)
    );

    rnu_div #(
        .MAG_W (MAG_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_start),
        .i_dividend (w_dividend),
        .i_divisor  (r_g),
        .o_sts      (w_div_sts),
        .o_quotient (w_quotient)
    );

    // Sequencer with the registered result.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_gcd_start <= 1'b0;
            r_div_start <= 1'b0;
            o_out_valid <= 1'b0;
        end else begin
            r_gcd_start <= 1'b0;
            r_div_start <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_na  <= w_na;
                        r_da  <= w_da;
                        r_neg <= i_numerator_in[DATA_WIDTH-1] ^
                                 i_denominator_in[DATA_WIDTH-1];
                        if (w_na == '0 || w_da == '0) begin
                            // Zero numerator gives 0/1; zero denominator with a nonzero numerator flags.
                            o_numerator_out   <= '0;
                            o_denominator_out <= MAG_W'(1);
                            o_zero_divisor    <= (w_na != '0);
                            o_out_valid       <= 1'b1;
                            r_state           <= S_OUT;
                        end else begin
                            r_gcd_start <= 1'b1;
                            r_state     <= S_GCD;
                        end
                    end
                end
                S_GCD: begin
                    if (w_gcd_sts.done) begin
                        r_g         <= w_gcd;
                        r_div_start <= 1'b1;
                        r_state     <= S_DIVN;
                    end
                end
                S_DIVN: begin
                    if (w_div_sts.done) begin
                        r_qn        <= w_quotient;
                        r_div_start <= 1'b1;
                        r_state     <= S_DIVD;
                    end
                end
                S_DIVD: begin
                    if (w_div_sts.done) begin
                        o_numerator_out   <= r_neg ? (-w_qn_ext) : w_qn_ext;
                        o_denominator_out <= w_quotient;
                        o_zero_divisor    <= 1'b0;
                        o_out_valid       <= 1'b1;
                        r_state           <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (i_out_ready) begin
                        o_out_valid <= 1'b0;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    // A finished item never shares the cycle with a new acceptance.
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("input accepted while a result is pending");

    // A delivered denominator is never zero.
    a_den_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_denominator_out != '0))
        else $error("zero denominator in result");

    // The error flag always comes with the forced result 0/1.
    a_flag_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_zero_divisor) |->
            (o_numerator_out == '0 && o_denominator_out == MAG_W'(1)))
        else $error("zero divisor flag without 0/1 result");

    // The gcd unit only finishes while the sequencer waits for it.
    a_gcd_in_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_gcd_sts.done |-> (r_state == S_GCD))
        else $error("gcd finished outside its phase");

    // The gcd unit and the divider never work at the same time.
    a_one_unit_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_gcd_sts.busy && w_div_sts.busy))
        else $error("gcd unit and divider busy together");

endmodule

`default_nettype wire

// File: tb/rational_normalizer_unit_tb.sv
// ----------------------------------------------------------------------------
// rational_normalizer_unit_tb: self-checking bench for the fraction reducer
// Sends signed numerator/denominator items through the valid/ready input,
// predicts each reduced fraction in the bench and compares every field of
// every result taken from the output channel. Directed cases cover the zero
// operands, sign placement and the extreme magnitudes. Random fractions with
// shared factors, full-range operands and small values follow, under three
// idling patterns on the two channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rational_normalizer_unit_tb
    import rnu_pkg::*;
;

    localparam int W = DATA_WIDTH_DEF;
    localparam real CLK_PERIOD = 12.0;
    localparam int RESET_CYCLES = 8;
    localparam int SETTLE_CYCLES = 4 * W + 16;
    localparam longint TIMEOUT_CYCLES = 900_000;

    localparam logic signed [W-1:0] MAX_POS = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] MOST_NEG = {1'b1, {(W-1){1'b0}}};

    // One reduced fraction as the block reports it.
    typedef struct {
        logic signed [W-1:0] num;
        logic        [W-2:0] den;
        logic                zero_div;
    } t_fraction;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_in_valid = 1'b0;
    logic                o_in_ready;
    logic signed [W-1:0] i_numerator_in = '0;
    logic signed [W-1:0] i_denominator_in = '0;
    logic                o_out_valid;
    logic                i_out_ready = 1'b0;
    logic signed [W-1:0] o_numerator_out;
    logic        [W-2:0] o_denominator_out;
    logic                o_zero_divisor;

    t_fraction expected_fractions[$];
    int        error_count = 0;
    int        tx_idle_pct = 23;
    int        rx_idle_pct = 59;

    rational_normalizer_unit #(
        .DATA_WIDTH(W)
    ) i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_numerator_in   (i_numerator_in),
        .i_denominator_in (i_denominator_in),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_numerator_out  (o_numerator_out),
        .o_denominator_out(o_denominator_out),
        .o_zero_divisor   (o_zero_divisor)
    );

    always #(CLK_PERIOD / 2.0) i_clk = ~i_clk;

    // Magnitude of a signed operand; the most negative value saturates.
    function automatic logic [W-1:0] operand_magnitude(input logic signed [W-1:0] value);
        logic [W-1:0] mag;
        mag = value[W-1] ? -value : value;
        if (mag[W-1]) begin
            mag = MAX_POS;
        end
        return mag;
    endfunction

    // Greatest common divisor by repeated remainders.
    function automatic logic [W-1:0] common_divisor(input logic [W-1:0] a,
                                                    input logic [W-1:0] b);
        logic [W-1:0] rem;
        while (b != '0) begin
            rem = a % b;
            a = b;
            b = rem;
        end
        return a;
    endfunction

    // Expected result for one numerator/denominator item.
    function automatic t_fraction reduce_fraction(input logic signed [W-1:0] num,
                                                  input logic signed [W-1:0] den);
        t_fraction    res;
        logic [W-1:0] num_mag;
        logic [W-1:0] den_mag;
        logic [W-1:0] gcd;
        logic [W-1:0] red_num;
        logic [W-1:0] red_den;
        num_mag = operand_magnitude(num);
        den_mag = operand_magnitude(den);
        res.num = '0;
        res.den = (W-1)'(1);
        res.zero_div = 1'b0;
        if (num_mag == '0) begin
            return res;
        end
        if (den_mag == '0) begin
            res.zero_div = 1'b1;
            return res;
        end
        gcd = common_divisor(num_mag, den_mag);
        red_num = num_mag / gcd;
        red_den = den_mag / gcd;
        res.num = (num[W-1] != den[W-1]) ? -red_num : red_num;
        res.den = red_den[W-2:0];
        return res;
    endfunction

    // Applies a random sign to a magnitude.
    function automatic logic signed [W-1:0] random_sign(input longint unsigned mag);
        logic signed [W-1:0] value;
        value = mag[W-1:0];
        return ($urandom_range(1) == 1) ? -value : value;
    endfunction

    // Sends one item, idling beforehand at the current rate, and records
    // its expected result once the block accepts it. Starts and ends on a
    // falling edge.
    task automatic send_fraction(input logic signed [W-1:0] num,
                                 input logic signed [W-1:0] den);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_numerator_in = num;
        i_denominator_in = den;
        @(posedge i_clk);
        while (!o_in_ready) begin
            @(posedge i_clk);
        end
        expected_fractions.push_back(reduce_fraction(num, den));
        @(negedge i_clk);
        i_in_valid = 1'b0;
        i_numerator_in = $urandom;
        i_denominator_in = $urandom;
    endtask

    // Waits until every expected result has been taken.
    task automatic wait_for_results();
        while (expected_fractions.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    // Zero numerator gives 0/1; zero denominator under a nonzero numerator
    // raises the error flag.
    task automatic test_zero_operands();
        send_fraction('0, '0);
        send_fraction('0, 5);
        send_fraction('0, -5);
        send_fraction('0, MOST_NEG);
        send_fraction(7, '0);
        send_fraction(-7, '0);
        send_fraction(MAX_POS, '0);
        send_fraction(MOST_NEG, '0);
        wait_for_results();
    endtask

    // The sign lands on the numerator for every sign combination.
    task automatic test_sign_placement();
        send_fraction(1, 1);
        send_fraction(-1, 1);
        send_fraction(1, -1);
        send_fraction(-1, -1);
        send_fraction(6, 4);
        send_fraction(-6, 4);
        send_fraction(6, -4);
        send_fraction(-6, -4);
        wait_for_results();
    endtask

    // Full-scale magnitudes, including the saturated most negative value.
    task automatic test_extreme_magnitudes();
        send_fraction(MAX_POS, MAX_POS);
        send_fraction(MAX_POS, -MAX_POS);
        send_fraction(MOST_NEG, MAX_POS);
        send_fraction(MOST_NEG, MOST_NEG);
        send_fraction(MAX_POS, 1);
        send_fraction(1, MAX_POS);
        send_fraction(-MAX_POS, -1);
        send_fraction(1 <<< 30, 1 <<< 20);
        send_fraction(12345678, -87654321);
        wait_for_results();
    endtask

    // Random fractions under one idling pattern. On average three items in
    // ten are built on a shared factor so that the reduction does real work.
    task automatic test_random_fractions(input int count, input int tx_pct,
                                         input int rx_pct);
        logic signed [W-1:0] num;
        logic signed [W-1:0] den;
        longint unsigned     factor;
        longint unsigned     span;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        repeat (count) begin
            case ($urandom_range(9))
                0: begin
                    num = '0;
                    den = ($urandom_range(3) == 0) ? '0 : $urandom;
                end
                1: begin
                    num = $urandom;
                    den = '0;
                end
                2, 3, 4: begin
                    factor = $urandom_range(1, 1 << $urandom_range(0, 16));
                    span = longint'(MAX_POS) / factor;
                    num = random_sign(factor * (1 + ($urandom % span)));
                    den = random_sign(factor * (1 + ($urandom % span)));
                end
                5, 6, 7: begin
                    num = $urandom;
                    den = $urandom;
                end
                8: begin
                    num = $urandom_range(40) - 20;
                    den = $urandom_range(40) - 20;
                end
                default: begin
                    num = ($urandom_range(3) == 0) ? MOST_NEG
                        : random_sign(longint'(MAX_POS) >> $urandom_range(W - 1));
                    den = ($urandom_range(3) == 0) ? MOST_NEG
                        : random_sign(longint'(MAX_POS) >> $urandom_range(W - 1));
                end
            endcase
            send_fraction(num, den);
        end
        wait_for_results();
    endtask

    // Receiver: stalls at the current rate, changing at the falling edge.
    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // Compare every taken result with the oldest expectation.
    always @(posedge i_clk) begin
        t_fraction exp_frac;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_fractions.size() == 0) begin
                $display("%0t: result %0d/%0d flag %0b with no item outstanding",
                         $time, o_numerator_out, o_denominator_out, o_zero_divisor);
                error_count++;
            end else begin
                exp_frac = expected_fractions.pop_front();
                if (o_numerator_out !== exp_frac.num) begin
                    $display("%0t: numerator expected %0d actual %0d",
                             $time, exp_frac.num, o_numerator_out);
                    error_count++;
                end
                if (o_denominator_out !== exp_frac.den) begin
                    $display("%0t: denominator expected %0d actual %0d",
                             $time, exp_frac.den, o_denominator_out);
                    error_count++;
                end
                if (o_zero_divisor !== exp_frac.zero_div) begin
                    $display("%0t: zero divisor flag expected %0b actual %0b",
                             $time, exp_frac.zero_div, o_zero_divisor);
                    error_count++;
                end
            end
        end
    end

    // Sequence of tests.
    initial begin
        repeat (RESET_CYCLES) begin
            @(posedge i_clk);
        end
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_zero_operands();
        test_sign_placement();
        test_extreme_magnitudes();
        test_random_fractions(400, 23, 59);
        test_random_fractions(400, 59, 23);
        test_random_fractions(400, 0, 0);

        repeat (SETTLE_CYCLES) begin
            @(negedge i_clk);
        end
        if (error_count == 0 && expected_fractions.size() == 0) begin
            $display("[rational_normalizer_unit] OK");
        end else begin
            $display("[rational_normalizer_unit] ERROR");
        end
        $finish;
    end

    // Guard against a hung handshake.
    initial begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("[rational_normalizer_unit] ERROR");
        $finish;
    end

endmodule

// File: rational_normalizer_unit.f
hw/rtl/rnu_pkg.sv
hw/rtl/rnu_gcd.sv
hw/rtl/rnu_div.sv
hw/rtl/rational_normalizer_unit.sv
tb/rational_normalizer_unit_tb.sv
